@@ sv/kpec_pkg.sv @@
package kpec_pkg;

	// request codes
	localparam logic [2:0] REQ_KEY_DOWN = 3'd0;
	localparam logic [2:0] REQ_KEY_UP   = 3'd1;
	localparam logic [2:0] REQ_POP      = 3'd2;
	localparam logic [2:0] REQ_REQUEUE  = 3'd3;
	localparam logic [2:0] REQ_READ_MAP = 3'd4;
	localparam logic [2:0] REQ_CLEAR    = 3'd5;

	localparam int REQ_W      = 3;
	localparam int KEY_W      = 8;
	localparam int KEY_COUNT  = 256;
	localparam int SLICE_W    = 64;
	localparam int SLICE_SEL_W = 2;

	localparam int QUEUE_DEPTH_DEF = 128;

	// modifier key codes, left/right variants after the generic one
	localparam logic [KEY_W-1:0] KEY_SHIFT    = 8'h10;
	localparam logic [KEY_W-1:0] KEY_LSHIFT   = 8'hA0;
	localparam logic [KEY_W-1:0] KEY_RSHIFT   = 8'hA1;
	localparam logic [KEY_W-1:0] KEY_CONTROL  = 8'h11;
	localparam logic [KEY_W-1:0] KEY_LCONTROL = 8'hA2;
	localparam logic [KEY_W-1:0] KEY_RCONTROL = 8'hA3;
	localparam logic [KEY_W-1:0] KEY_ALT      = 8'h12;
	localparam logic [KEY_W-1:0] KEY_LALT     = 8'hA4;
	localparam logic [KEY_W-1:0] KEY_RALT     = 8'hA5;

	// one queued press
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             shift;
		logic             control;
		logic             alt;
	} event_t;

	localparam int EVENT_W = $bits(event_t);

endpackage

@@ sv/kpec_ram.sv @@
module kpec_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/key_press_event_capture.sv @@
// Key press capture: a map of keys held down and a queue of press events.
//
// Request channel: a request beat is taken on a rising edge with start high
// and busy low. busy is never raised, so a request may be given every cycle.
// Requests: key down, key up, pop event, requeue at head, read map slice,
// clear. Codes 6 and 7 are dropped without a result and change nothing.
//
// Result channel: every other request gives exactly one result beat, shown
// for one cycle with result_strobe high, once the request has passed the
// input register and then the result register and event memory read
// register.
// Results come out in request order at one per cycle; the receiver cannot
// stall and must take each beat as it comes.
//
// The event queue sits in a one-port-write, one-port-read memory; each
// request does at most one access to it, so one request per cycle is held.
// Reset clears the key map (all keys up), the queue head and the count at
// once; queue entries are not cleared, only entries holding events are read.
module key_press_event_capture #(
	parameter int QUEUE_DEPTH = kpec_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [kpec_pkg::REQ_W-1:0]          req_type,
	input  logic [kpec_pkg::KEY_W-1:0]          key_code,
	input  logic                                shift_in,
	input  logic                                control_in,
	input  logic                                alt_in,
	input  logic [kpec_pkg::SLICE_SEL_W-1:0]    slice_index,
	output logic                                result_strobe,
	output logic                                event_valid,
	output logic [kpec_pkg::KEY_W-1:0]          event_key,
	output logic                                event_shift,
	output logic                                event_control,
	output logic                                event_alt,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]    events_left,
	output logic [kpec_pkg::SLICE_W-1:0]        down_slice
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(QUEUE_DEPTH);

	// input register
	logic                                 valid_s1;
	logic [kpec_pkg::REQ_W-1:0]           req_s1;
	logic [kpec_pkg::KEY_W-1:0]           key_s1;
	logic                                 shift_s1;
	logic                                 control_s1;
	logic                                 alt_s1;
	logic [kpec_pkg::SLICE_SEL_W-1:0]     slice_s1;

	// block state
	logic [kpec_pkg::KEY_COUNT-1:0]       down_map_q;
	logic [PTR_W-1:0]                     head_q;
	logic [CNT_W-1:0]                     count_q;

	// result register
	logic                                 strobe_s2;
	logic                                 pop_hit_s2;
	logic [CNT_W-1:0]                     left_s2;
	logic [kpec_pkg::SLICE_W-1:0]         slice_s2;

	// next-state and memory controls
	logic [PTR_W-1:0]                     head_nxt;
	logic [CNT_W-1:0]                     count_nxt;
	logic                                 has_result;
	logic                                 pop_hit;
	logic [kpec_pkg::SLICE_W-1:0]         slice_nxt;
	logic                                 ram_we;
	logic                                 ram_re;
	logic [PTR_W-1:0]                     ram_waddr;
	kpec_pkg::event_t                     ram_wdata;
	kpec_pkg::event_t                     ram_rdata;

	logic                                 full;
	logic                                 key_was_down;
	logic [PTR_W-1:0]                     head_inc;
	logic [PTR_W-1:0]                     head_dec;
	logic [PTR_W:0]                       tail_sum;
	logic [PTR_W-1:0]                     tail;
	logic                                 shift_flag;
	logic                                 control_flag;
	logic                                 alt_flag;

	assign busy = 1'b0;

	// request beat into the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1     <= req_type;
			key_s1     <= key_code;
			shift_s1   <= shift_in;
			control_s1 <= control_in;
			alt_s1     <= alt_in;
			slice_s1   <= slice_index;
		end
	end

	// queue pointer arithmetic
	assign full         = (count_q == FULL_CNT);
	assign head_inc     = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
	assign head_dec     = (head_q == '0) ? LAST_PTR : head_q - 1'b1;
	assign tail_sum     = {1'b0, head_q} + {1'b0, count_q[PTR_W-1:0]};
	assign tail         = (tail_sum >= DEPTH_EXT) ? PTR_W'(tail_sum - DEPTH_EXT)
	                                              : tail_sum[PTR_W-1:0];
	assign key_was_down = down_map_q[key_s1];

	// modifier flags: held in the map or the pressed key itself
	assign shift_flag = down_map_q[kpec_pkg::KEY_SHIFT] || down_map_q[kpec_pkg::KEY_LSHIFT] ||
	                    down_map_q[kpec_pkg::KEY_RSHIFT] || key_s1 == kpec_pkg::KEY_SHIFT ||
	                    key_s1 == kpec_pkg::KEY_LSHIFT || key_s1 == kpec_pkg::KEY_RSHIFT;
	assign control_flag = down_map_q[kpec_pkg::KEY_CONTROL] ||
	                      down_map_q[kpec_pkg::KEY_LCONTROL] ||
	                      down_map_q[kpec_pkg::KEY_RCONTROL] ||
	                      key_s1 == kpec_pkg::KEY_CONTROL ||
	                      key_s1 == kpec_pkg::KEY_LCONTROL ||
	                      key_s1 == kpec_pkg::KEY_RCONTROL;
	assign alt_flag = down_map_q[kpec_pkg::KEY_ALT] || down_map_q[kpec_pkg::KEY_LALT] ||
	                  down_map_q[kpec_pkg::KEY_RALT] || key_s1 == kpec_pkg::KEY_ALT ||
	                  key_s1 == kpec_pkg::KEY_LALT || key_s1 == kpec_pkg::KEY_RALT;

	// request decode
	always_comb begin
		head_nxt   = head_q;
		count_nxt  = count_q;
		has_result = 1'b0;
		pop_hit    = 1'b0;
		slice_nxt  = '0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = tail;
		ram_wdata  = '{key: key_s1, shift: shift_flag, control: control_flag, alt: alt_flag};
		if (valid_s1) begin
			case (req_s1)
				kpec_pkg::REQ_KEY_DOWN: begin
					has_result = 1'b1;
					if (!key_was_down) begin
						ram_we = 1'b1;
						if (full) begin
							// overwrite the oldest slot and move past it
							ram_waddr = head_q;
							head_nxt  = head_inc;
						end else begin
							count_nxt = count_q + 1'b1;
						end
					end
				end
				kpec_pkg::REQ_KEY_UP: begin
					has_result = 1'b1;
				end
				kpec_pkg::REQ_POP: begin
					has_result = 1'b1;
					if (count_q != '0) begin
						ram_re    = 1'b1;
						pop_hit   = 1'b1;
						head_nxt  = head_inc;
						count_nxt = count_q - 1'b1;
					end
				end
				kpec_pkg::REQ_REQUEUE: begin
					has_result = 1'b1;
					ram_wdata  = '{key: key_s1, shift: shift_s1, control: control_s1,
					               alt: alt_s1};
					if (!full) begin
						ram_we    = 1'b1;
						ram_waddr = head_dec;
						head_nxt  = head_dec;
						count_nxt = count_q + 1'b1;
					end
				end
				kpec_pkg::REQ_READ_MAP: begin
					has_result = 1'b1;
					slice_nxt  = down_map_q[{slice_s1, 6'd0} +: kpec_pkg::SLICE_W];
				end
				kpec_pkg::REQ_CLEAR: begin
					has_result = 1'b1;
					head_nxt   = '0;
					count_nxt  = '0;
				end
				default: begin
					has_result = 1'b0;
				end
			endcase
		end
	end

	// key map, queue pointers and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_map_q <= '0;
			head_q     <= '0;
			count_q    <= '0;
			strobe_s2  <= 1'b0;
			pop_hit_s2 <= 1'b0;
		end else begin
			head_q     <= head_nxt;
			count_q    <= count_nxt;
			strobe_s2  <= has_result;
			pop_hit_s2 <= pop_hit;
			if (valid_s1) begin
				case (req_s1)
					kpec_pkg::REQ_KEY_DOWN: down_map_q[key_s1] <= 1'b1;
					kpec_pkg::REQ_KEY_UP:   down_map_q[key_s1] <= 1'b0;
					kpec_pkg::REQ_CLEAR:    down_map_q <= '0;
					default:                down_map_q <= down_map_q;
				endcase
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		left_s2  <= count_nxt;
		slice_s2 <= slice_nxt;
	end

	// event store
	kpec_ram #(
		.WIDTH(kpec_pkg::EVENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_event_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	// result ports, event fields zero unless a pop found an event
	assign result_strobe = strobe_s2;
	assign event_valid   = pop_hit_s2;
	assign event_key     = pop_hit_s2 ? ram_rdata.key : '0;
	assign event_shift   = pop_hit_s2 && ram_rdata.shift;
	assign event_control = pop_hit_s2 && ram_rdata.control;
	assign event_alt     = pop_hit_s2 && ram_rdata.alt;
	assign events_left   = left_s2;
	assign down_slice    = slice_s2;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("event count above queue depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LAST_PTR)
		else $error("queue head out of range");

	a_left_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (events_left == count_q))
		else $error("events left differs from queue count");

	a_pop_takes_one: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid |-> (result_strobe && count_q == $past(count_q) - 1'b1))
		else $error("pop did not remove exactly one event");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid |-> ($past(count_q) != '0))
		else $error("pop hit on an empty queue");

endmodule

@@ dv/key_press_checker.sv @@
module key_press_checker
	import kpec_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic [REQ_W-1:0]                    req_type,
	input  logic [KEY_W-1:0]                    key_code,
	input  logic                                shift_in,
	input  logic                                control_in,
	input  logic                                alt_in,
	input  logic [SLICE_SEL_W-1:0]              slice_index,
	input  logic                                result_strobe,
	input  logic                                event_valid,
	input  logic [KEY_W-1:0]                    event_key,
	input  logic                                event_shift,
	input  logic                                event_control,
	input  logic                                event_alt,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    events_left,
	input  logic [SLICE_W-1:0]                  down_slice,
	output int                                  fail_count,
	output int                                  outstanding
);

	localparam int LEFT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct {
		logic                ev_valid;
		event_t              ev;
		logic [LEFT_W-1:0]   left;
		logic [SLICE_W-1:0]  slice;
	} press_result_t;

	// shadow of the key map and the press queue
	logic [KEY_COUNT-1:0] keys_held;
	event_t               ring [QUEUE_DEPTH];
	int                   head;
	int                   queued;
	int                   mismatches = 0;
	press_result_t        owed_results [$];

	// modifier flag: one of its codes held, or the pressed key is one of them
	function automatic logic modifier_held(logic [KEY_W-1:0] key, logic [KEY_W-1:0] a,
			logic [KEY_W-1:0] b, logic [KEY_W-1:0] c);
		return keys_held[a] | keys_held[b] | keys_held[c] |
			(key == a) | (key == b) | (key == c);
	endfunction

	task automatic report(string what, logic [SLICE_W-1:0] got, logic [SLICE_W-1:0] want);
		$display("%0t checker: %s got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// work out the result of one accepted request beat and update the shadow
	task automatic apply_request();
		press_result_t r;
		event_t        ev;
		r.ev_valid = 1'b0;
		r.ev = '0;
		r.slice = '0;
		case (req_type)
			REQ_KEY_DOWN: begin
				if (!keys_held[key_code]) begin
					ev.key = key_code;
					ev.shift = modifier_held(key_code, KEY_SHIFT, KEY_LSHIFT, KEY_RSHIFT);
					ev.control = modifier_held(key_code, KEY_CONTROL, KEY_LCONTROL,
						KEY_RCONTROL);
					ev.alt = modifier_held(key_code, KEY_ALT, KEY_LALT, KEY_RALT);
					// full queue loses its oldest press
					if (queued >= QUEUE_DEPTH) begin
						head = (head + 1) % QUEUE_DEPTH;
						queued = QUEUE_DEPTH - 1;
					end
					ring[(head + queued) % QUEUE_DEPTH] = ev;
					queued++;
				end
				keys_held[key_code] = 1'b1;
			end
			REQ_KEY_UP: begin
				keys_held[key_code] = 1'b0;
			end
			REQ_POP: begin
				if (queued > 0) begin
					r.ev_valid = 1'b1;
					r.ev = ring[head];
					head = (head + 1) % QUEUE_DEPTH;
					queued--;
				end
			end
			REQ_REQUEUE: begin
				// requeue onto a full queue is thrown away
				if (queued < QUEUE_DEPTH) begin
					head = (head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
					ring[head] = {key_code, shift_in, control_in, alt_in};
					queued++;
				end
			end
			REQ_READ_MAP: begin
				r.slice = keys_held[slice_index * SLICE_W +: SLICE_W];
			end
			REQ_CLEAR: begin
				keys_held = '0;
				head = 0;
				queued = 0;
			end
			default: begin
				// unused codes leave no trace
				return;
			end
		endcase
		r.left = LEFT_W'(queued);
		owed_results.insert(owed_results.size(), r);
	endtask

	// compare one result beat with the oldest owed result
	task automatic check_result();
		press_result_t want;
		if (owed_results.size() == 0) begin
			report("result beat with nothing owed, down_slice", down_slice, '0);
		end else begin
			want = owed_results.pop_front();
			if (event_valid !== want.ev_valid)
				report("event_valid", event_valid, want.ev_valid);
			if (event_key !== want.ev.key)
				report("event_key", event_key, want.ev.key);
			if (event_shift !== want.ev.shift)
				report("event_shift", event_shift, want.ev.shift);
			if (event_control !== want.ev.control)
				report("event_control", event_control, want.ev.control);
			if (event_alt !== want.ev.alt)
				report("event_alt", event_alt, want.ev.alt);
			if (events_left !== want.left)
				report("events_left", events_left, want.left);
			if (down_slice !== want.slice)
				report("down_slice", down_slice, want.slice);
		end
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_held = '0;
			head = 0;
			queued = 0;
			owed_results.delete();
		end else begin
			if (result_strobe)
				check_result();
			if (start && !busy)
				apply_request();
		end
		outstanding <= owed_results.size();
		fail_count <= mismatches;
	end

endmodule

@@ dv/key_press_event_capture_tb.sv @@
module key_press_event_capture_tb;

	import kpec_pkg::*;

	localparam int ITEMS      = 1450;
	localparam int PHASE_LEN  = 480;
	localparam int STALL_LIMIT = 2000;

	logic                                    clk = 1'b0;
	logic                                    arst_n = 1'b0;
	logic                                    start = 1'b0;
	logic                                    busy;
	logic [REQ_W-1:0]                        req_type = '0;
	logic [KEY_W-1:0]                        key_code = '0;
	logic                                    shift_in = 1'b0;
	logic                                    control_in = 1'b0;
	logic                                    alt_in = 1'b0;
	logic [SLICE_SEL_W-1:0]                  slice_index = '0;
	logic                                    result_strobe;
	logic                                    event_valid;
	logic [KEY_W-1:0]                        event_key;
	logic                                    event_shift;
	logic                                    event_control;
	logic                                    event_alt;
	logic [$clog2(QUEUE_DEPTH_DEF+1)-1:0]    events_left;
	logic [SLICE_W-1:0]                      down_slice;
	int                                      fail_count;
	int                                      outstanding;

	int items_sent = 0;
	int stall_cycles = 0;

	logic [KEY_W-1:0] mod_codes [9] = '{KEY_SHIFT, KEY_LSHIFT, KEY_RSHIFT, KEY_CONTROL,
		KEY_LCONTROL, KEY_RCONTROL, KEY_ALT, KEY_LALT, KEY_RALT};

	key_press_event_capture dut (.*);

	key_press_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog on cycles in which no beat moves on either side
	always @(posedge clk) begin
		if ((start && !busy) || result_strobe)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// sender gap with junk on the fields
	task automatic hold_off(int cycles);
		start <= 1'b0;
		req_type <= REQ_W'($urandom);
		key_code <= KEY_W'($urandom);
		{shift_in, control_in, alt_in} <= 3'($urandom);
		slice_index <= SLICE_SEL_W'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// one request beat; each cycle idles with the phase's odds in the idling phases
	task automatic beat(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key, logic [2:0] flags,
			logic [SLICE_SEL_W-1:0] sel);
		int idle_pct;
		idle_pct = (items_sent < PHASE_LEN) ? 25 : (items_sent < 2 * PHASE_LEN) ? 46 : 0;
		while ($urandom_range(99) < idle_pct)
			hold_off(1);
		start <= 1'b1;
		req_type <= req;
		key_code <= key;
		{shift_in, control_in, alt_in} <= flags;
		slice_index <= sel;
		do @(posedge clk); while (busy);
		if (req <= REQ_CLEAR)
			items_sent++;
	endtask

	task automatic quick(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key);
		beat(req, key, 3'($urandom), SLICE_SEL_W'($urandom));
	endtask

	task automatic read_slice(logic [SLICE_SEL_W-1:0] sel);
		beat(REQ_READ_MAP, KEY_W'($urandom), 3'($urandom), sel);
	endtask

	// stop sending until every owed result has come back
	task automatic settle();
		hold_off(1);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(99) < 25)
			return mod_codes[$urandom_range(8)];
		return KEY_W'($urandom_range(255));
	endfunction

	// press and release pairs, most released at once so the next press queues
	task automatic press_run(int pairs);
		logic [KEY_W-1:0] k;
		for (int i = 0; i < pairs; i++) begin
			k = pick_key();
			quick(REQ_KEY_DOWN, k);
			if ($urandom_range(99) < 75)
				quick(REQ_KEY_UP, k);
			if ($urandom_range(99) < 10)
				quick(REQ_POP, '0);
		end
	endtask

	initial begin
		logic [KEY_W-1:0] chord [4];
		int               kind;
		int               n;
		int               m;
		bit               first_run;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, modifiers, repeats, map reads, requeue, pops, unused codes and clear
		read_slice(2'd1);
		quick(REQ_POP, '0);
		quick(REQ_KEY_DOWN, 8'h00);
		quick(REQ_KEY_DOWN, 8'hFF);
		quick(REQ_KEY_DOWN, KEY_SHIFT);
		quick(REQ_KEY_DOWN, 8'h41);
		quick(REQ_KEY_DOWN, KEY_LCONTROL);
		quick(REQ_KEY_DOWN, KEY_RALT);
		quick(REQ_KEY_DOWN, 8'h42);
		quick(REQ_KEY_DOWN, 8'h41);
		quick(REQ_KEY_UP, KEY_SHIFT);
		quick(REQ_KEY_UP, 8'h41);
		quick(REQ_KEY_DOWN, 8'h41);
		read_slice(2'd0);
		read_slice(2'd2);
		read_slice(2'd3);
		beat(REQ_REQUEUE, 8'hFF, 3'b111, 2'd0);
		beat(REQ_REQUEUE, 8'h00, 3'b000, 2'd3);
		quick(REQ_POP, '0);
		quick(REQ_POP, '0);
		quick(3'd6, 8'hFF);
		quick(3'd7, 8'h00);
		quick(REQ_CLEAR, '0);
		read_slice(2'd2);
		quick(REQ_POP, '0);
		settle();

		// random episodes; the first one always overruns the queue
		first_run = 1'b1;
		while (items_sent < ITEMS) begin
			kind = first_run ? 88 : $urandom_range(99);
			first_run = 1'b0;
			if (kind < 40) begin
				press_run($urandom_range(4, 40));
			end else if (kind < 55) begin
				// chord of modifiers around a plain key
				m = $urandom_range(1, 3);
				for (int i = 0; i < m; i++) begin
					chord[i] = mod_codes[$urandom_range(8)];
					quick(REQ_KEY_DOWN, chord[i]);
				end
				chord[m] = KEY_W'($urandom_range(255));
				quick(REQ_KEY_DOWN, chord[m]);
				if ($urandom_range(1))
					quick(REQ_POP, '0);
				for (int i = 0; i <= m; i++)
					if ($urandom_range(99) < 80)
						quick(REQ_KEY_UP, chord[i]);
			end else if (kind < 70) begin
				n = ($urandom_range(9) == 0) ? 140 : $urandom_range(1, 20);
				repeat (n) quick(REQ_POP, '0);
			end else if (kind < 78) begin
				n = $urandom_range(1, 10);
				repeat (n) quick(REQ_REQUEUE, KEY_W'($urandom_range(255)));
			end else if (kind < 86) begin
				n = $urandom_range(1, 4);
				repeat (n) read_slice(SLICE_SEL_W'($urandom));
				n = $urandom_range(1, 3);
				repeat (n) quick(REQ_KEY_UP, pick_key());
			end else if (kind < 88) begin
				settle();
			end else if (kind < 92) begin
				// overrun: more presses than slots, then requeue onto the full queue
				n = $urandom_range(130, 150);
				for (int i = 0; i < n; i++) begin
					chord[0] = KEY_W'($urandom_range(255));
					quick(REQ_KEY_DOWN, chord[0]);
					quick(REQ_KEY_UP, chord[0]);
				end
				repeat (2) quick(REQ_REQUEUE, KEY_W'($urandom_range(255)));
				n = $urandom_range(1, 5);
				repeat (n) quick(REQ_POP, '0);
				read_slice(SLICE_SEL_W'($urandom));
			end else if (kind < 95) begin
				quick(REQ_CLEAR, '0);
			end else begin
				// unused codes and a fully random beat
				n = $urandom_range(1, 3);
				repeat (n) quick(REQ_W'($urandom_range(6, 7)), KEY_W'($urandom));
				quick(REQ_W'($urandom_range(7)), KEY_W'($urandom));
			end
		end

		settle();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ files.f @@
sv/kpec_pkg.sv
sv/kpec_ram.sv
sv/key_press_event_capture.sv
dv/key_press_checker.sv
dv/key_press_event_capture_tb.sv
